/* rtl/tlv_frame_receiver_macros.svh */
// Assertion macros for the checker file of the TLV frame receiver
`ifndef TLV_FRAME_RECEIVER_MACROS_SVH
`define TLV_FRAME_RECEIVER_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define TLVFR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies another one in the following cycle
`define TLVFR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/tlvfr_pkg.sv */
// Shared types and constants of the TLV frame receiver
`timescale 1ns / 1ps

package tlvfr_pkg;

  localparam int unsigned BYTE_W            = 8;
  localparam int unsigned PAYLOAD_DEPTH_DEF = 256;

  localparam logic [BYTE_W-1:0] HEADER_RST = 8'hAA;
  localparam logic [BYTE_W-1:0] CHECK_RST  = 8'hEE;

  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_OK   = 2'd1,
    EV_BAD  = 2'd2
  } event_e;

  typedef enum logic {
    CFG_HEADER = 1'b0,
    CFG_CHECK  = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    MODE_RECV = 1'b0,
    MODE_READ = 1'b1
  } mode_e;

endpackage

/* rtl/tlvfr_in_if.sv */
// Input channel of the TLV frame receiver: one stream byte or one read request
`timescale 1ns / 1ps

interface tlvfr_in_if;
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic [tlvfr_pkg::BYTE_W-1:0]  data_byte;
  logic [tlvfr_pkg::BYTE_W-1:0]  read_index;

  modport source (output valid, mode, data_byte, read_index, input ready);
  modport sink (input valid, mode, data_byte, read_index, output ready);
endinterface

/* rtl/tlvfr_out_if.sv */
// Output channel of the TLV frame receiver: event, frame info and read data
`timescale 1ns / 1ps

interface tlvfr_out_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    event_res;
  logic [tlvfr_pkg::BYTE_W-1:0]  frame_tag;
  logic [tlvfr_pkg::BYTE_W-1:0]  frame_length;
  logic [tlvfr_pkg::BYTE_W-1:0]  payload_byte;

  modport source (output valid, event_res, frame_tag, frame_length, payload_byte,
                  input ready);
  modport sink (input valid, event_res, frame_tag, frame_length, payload_byte,
                output ready);
endinterface

/* rtl/tlvfr_payload_buf.sv */
// Payload byte buffer: one write port, one registered read port
`timescale 1ns / 1ps

module tlvfr_payload_buf #(
  parameter int unsigned DEPTH = tlvfr_pkg::PAYLOAD_DEPTH_DEF,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                         clk_i,
  input  logic                         wr_en_i,
  input  logic [AW-1:0]                wr_addr_i,
  input  logic [tlvfr_pkg::BYTE_W-1:0] wr_data_i,
  input  logic                         rd_en_i,
  input  logic [AW-1:0]                rd_addr_i,
  output logic [tlvfr_pkg::BYTE_W-1:0] rd_data_o
);

  logic [tlvfr_pkg::BYTE_W-1:0] mem_q [DEPTH];
  logic [tlvfr_pkg::BYTE_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* rtl/tlv_frame_receiver.sv */
// TLV frame receiver top level: header hunt, tag/length capture, payload store, check
//
//   channel  dir  handshake      payload
//   rx_i     in   valid/ready    mode, data_byte, read_index
//   tx_o     out  valid/ready    event_res, frame_tag, frame_length, payload_byte
//   cfg      in   cfg_we_i       cfg_idx_i, cfg_wdata_i (header byte, check value)
//
// One item per cycle: each accepted item gives one result in the output register
// on the next edge, and rx_i.ready stays high while that register is empty or
// being taken. Read data comes from the registered read port of the payload
// buffer. A stall on tx_o holds the result and drops rx_i.ready until the
// transfer completes. Reset returns to header hunt with tag and length at zero;
// the payload buffer is not cleared.
`timescale 1ns / 1ps

module tlv_frame_receiver #(
  parameter int unsigned PAYLOAD_DEPTH = tlvfr_pkg::PAYLOAD_DEPTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [tlvfr_pkg::BYTE_W-1:0] cfg_wdata_i,
  tlvfr_in_if.sink                     rx_i,
  tlvfr_out_if.source                  tx_o
);

  localparam int unsigned AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
  localparam int unsigned BW = tlvfr_pkg::BYTE_W;

  typedef enum logic [2:0] {
    PH_HUNT  = 3'd0,
    PH_TAG   = 3'd1,
    PH_LEN   = 3'd2,
    PH_DATA  = 3'd3,
    PH_CHECK = 3'd4
  } phase_e;

  logic [BW-1:0]      header_q, check_q;
  phase_e             phase_q, phase_d;
  logic [BW-1:0]      pos_q, pos_d;
  logic [BW-1:0]      tag_q, tag_d;
  logic [BW-1:0]      len_q, len_d;
  tlvfr_pkg::event_e  ev_q, ev_d;
  logic               out_valid_q;
  logic               rd_hit_q, rd_hit_d;

  logic               accept;
  logic               recv;
  logic [BW-1:0]      b;
  logic [BW-1:0]      pos_inc;
  logic               wr_en;
  logic               rd_en;
  logic [BW-1:0]      rd_data;

  assign rx_i.ready = !out_valid_q || tx_o.ready;
  assign accept     = rx_i.valid && rx_i.ready;
  assign recv       = (rx_i.mode == tlvfr_pkg::MODE_RECV);
  assign b          = rx_i.data_byte;
  assign pos_inc    = pos_q + 8'd1;

  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    tag_d   = tag_q;
    len_d   = len_q;
    ev_d    = tlvfr_pkg::EV_NONE;
    wr_en   = 1'b0;
    if (recv) begin
      case (phase_q)
        PH_TAG: begin
          tag_d   = b;
          phase_d = PH_LEN;
        end
        PH_LEN: begin
          len_d   = b;
          phase_d = (b == '0) ? PH_CHECK : PH_DATA;
        end
        PH_DATA: begin
          // bytes past the buffer end are counted but not stored
          wr_en = ({1'b0, pos_q} < 9'(PAYLOAD_DEPTH));
          pos_d = pos_inc;
          if (pos_inc >= len_q) begin
            phase_d = PH_CHECK;
          end
        end
        PH_CHECK: begin
          ev_d    = (b == check_q) ? tlvfr_pkg::EV_OK : tlvfr_pkg::EV_BAD;
          phase_d = PH_HUNT;
        end
        default: begin
          if (b == header_q) begin
            pos_d   = '0;
            phase_d = PH_TAG;
          end else begin
            phase_d = PH_HUNT;
          end
        end
      endcase
    end
  end

  assign rd_en    = accept && !recv;
  assign rd_hit_d = !recv && (rx_i.read_index < len_q)
                    && ({1'b0, rx_i.read_index} < 9'(PAYLOAD_DEPTH));

  tlvfr_payload_buf #(
    .DEPTH (PAYLOAD_DEPTH),
    .AW    (AW)
  ) u_buf (
    .clk_i     (clk_i),
    .wr_en_i   (accept && wr_en),
    .wr_addr_i (pos_q[AW-1:0]),
    .wr_data_i (b),
    .rd_en_i   (rd_en),
    .rd_addr_i (rx_i.read_index[AW-1:0]),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q    <= tlvfr_pkg::HEADER_RST;
      check_q     <= tlvfr_pkg::CHECK_RST;
      phase_q     <= PH_HUNT;
      pos_q       <= '0;
      tag_q       <= '0;
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          tlvfr_pkg::CFG_HEADER: header_q <= cfg_wdata_i;
          tlvfr_pkg::CFG_CHECK:  check_q  <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (accept) begin
        phase_q     <= phase_d;
        pos_q       <= pos_d;
        tag_q       <= tag_d;
        len_q       <= len_d;
        out_valid_q <= 1'b1;
      end else if (tx_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload: event and read hit are captured with the item
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ev_q     <= ev_d;
      rd_hit_q <= rd_hit_d;
    end
  end

  assign tx_o.valid        = out_valid_q;
  assign tx_o.event_res    = ev_q;
  assign tx_o.frame_tag    = tag_q;
  assign tx_o.frame_length = len_q;
  assign tx_o.payload_byte = rd_hit_q ? rd_data : '0;

endmodule

/* rtl/tlvfr_checker.sv */
// Port-level checker for the TLV frame receiver, bound to the top level
`timescale 1ns / 1ps
`include "tlv_frame_receiver_macros.svh"

module tlvfr_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [1:0]                   out_event,
  input logic [tlvfr_pkg::BYTE_W-1:0] out_payload
);

  `TLVFR_ASSERT(a_event_code, clk_i, rst_ni,
    !out_valid || (out_event == tlvfr_pkg::EV_NONE) || (out_event == tlvfr_pkg::EV_OK)
    || (out_event == tlvfr_pkg::EV_BAD), "event code out of range")
  `TLVFR_ASSERT(a_event_no_read, clk_i, rst_ni,
    !out_valid || (out_event == tlvfr_pkg::EV_NONE) || (out_payload == '0),
    "event with read data")
  `TLVFR_ASSERT_NEXT(a_accept_result, clk_i, rst_ni, in_valid && in_ready, out_valid,
    "transfer gave no result")
  `TLVFR_ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, out_valid && !out_ready,
    out_valid && $stable(out_event) && $stable(out_payload), "stalled result changed")

endmodule

bind tlv_frame_receiver tlvfr_checker u_tlvfr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid    (rx_i.valid),
  .in_ready    (rx_i.ready),
  .out_valid   (tx_o.valid),
  .out_ready   (tx_o.ready),
  .out_event   (tx_o.event_res),
  .out_payload (tx_o.payload_byte)
);

/* tb/tb_tlv_frame_receiver.sv */
// Testbench for the TLV frame receiver: directed and random byte streams against a predictor
`timescale 1ns / 1ps

module tb_tlv_frame_receiver;

  localparam int unsigned BYTE_W          = tlvfr_pkg::BYTE_W;
  localparam int unsigned DEPTH           = tlvfr_pkg::PAYLOAD_DEPTH_DEF;
  localparam int unsigned WATCHDOG_LIMIT  = 2000;
  localparam int unsigned HOLD_CYCLES     = 80;
  localparam int unsigned ITEMS_PER_PHASE = 20;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_TAG,
    PH_LEN,
    PH_DATA,
    PH_CHECK
  } rx_phase_e;

  typedef struct packed {
    tlvfr_pkg::event_e ev;
    logic [BYTE_W-1:0] tag;
    logic [BYTE_W-1:0] len;
    logic [BYTE_W-1:0] pbyte;
  } frame_report_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  tlvfr_pkg::cfg_idx_e cfg_idx_i;
  logic [BYTE_W-1:0]   cfg_wdata_i;

  tlvfr_in_if  rx_if ();
  tlvfr_out_if tx_if ();

  tlv_frame_receiver u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rx_i        (rx_if),
    .tx_o        (tx_if)
  );

  // Predicted receiver state and configuration
  logic [BYTE_W-1:0] hdr_cfg;
  logic [BYTE_W-1:0] chk_cfg;
  rx_phase_e         rx_phase;
  logic [BYTE_W-1:0] rx_pos;
  logic [BYTE_W-1:0] rx_tag;
  logic [BYTE_W-1:0] rx_len;
  logic [BYTE_W-1:0] pl_mem [DEPTH];
  bit                pl_written [DEPTH];

  frame_report_t frame_reports[$];
  frame_report_t head_report;

  int error_count    = 0;
  int items_sent     = 0;
  int idle_cycles    = 0;
  int hold_request   = 0;
  int hold_left      = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  always #10 clk_i = ~clk_i;

  function automatic frame_report_t deframe_item(tlvfr_pkg::mode_e m, logic [BYTE_W-1:0] b,
                                                 logic [BYTE_W-1:0] idx);
    frame_report_t r;
    r.ev    = tlvfr_pkg::EV_NONE;
    r.pbyte = '0;
    if (m == tlvfr_pkg::MODE_READ) begin
      if (idx < rx_len) r.pbyte = pl_mem[idx];
    end else begin
      case (rx_phase)
        PH_TAG: begin
          rx_tag   = b;
          rx_phase = PH_LEN;
        end
        PH_LEN: begin
          rx_len   = b;
          rx_phase = (b == '0) ? PH_CHECK : PH_DATA;
        end
        PH_DATA: begin
          pl_mem[rx_pos]     = b;
          pl_written[rx_pos] = 1'b1;
          rx_pos             = rx_pos + 8'd1;
          if (rx_pos >= rx_len) rx_phase = PH_CHECK;
        end
        PH_CHECK: begin
          r.ev     = (b == chk_cfg) ? tlvfr_pkg::EV_OK : tlvfr_pkg::EV_BAD;
          rx_phase = PH_HUNT;
        end
        default: begin
          if (b == hdr_cfg) begin
            rx_pos   = '0;
            rx_phase = PH_TAG;
          end
        end
      endcase
    end
    r.tag = rx_tag;
    r.len = rx_len;
    return r;
  endfunction

  // Never point inside the current length at an entry that was never stored
  function automatic logic [BYTE_W-1:0] safe_read_index();
    logic [BYTE_W-1:0] idx;
    if ($urandom_range(3) == 0) idx = 8'($urandom_range(255));
    else idx = 8'($urandom_range(rx_len));
    if (idx < rx_len && !pl_written[idx]) idx = rx_len;
    return idx;
  endfunction

  function automatic void check_field(string name, logic [BYTE_W-1:0] e,
                                      logic [BYTE_W-1:0] a);
    if (a !== e) begin
      error_count++;
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, e, a);
    end
  endfunction

  task automatic send_item(tlvfr_pkg::mode_e m, logic [BYTE_W-1:0] b,
                           logic [BYTE_W-1:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      rx_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    rx_if.valid      <= 1'b1;
    rx_if.mode       <= m;
    rx_if.data_byte  <= b;
    rx_if.read_index <= idx;
    @(posedge clk_i);
    while (!rx_if.ready) @(posedge clk_i);
    items_sent++;
    frame_reports.push_back(deframe_item(m, b, idx));
  endtask

  task automatic send_byte(logic [BYTE_W-1:0] b);
    send_item(tlvfr_pkg::MODE_RECV, b, 8'($urandom_range(255)));
  endtask

  task automatic send_read(logic [BYTE_W-1:0] idx);
    send_item(tlvfr_pkg::MODE_READ, 8'($urandom_range(255)), idx);
  endtask

  task automatic send_noise(int n);
    logic [BYTE_W-1:0] b;
    repeat (n) begin
      b = 8'($urandom_range(255));
      if (b == hdr_cfg) b = b ^ 8'h01;
      send_byte(b);
    end
  endtask

  task automatic send_frame(logic [BYTE_W-1:0] tag, logic [BYTE_W-1:0] len, bit good,
                            bit with_reads);
    logic [BYTE_W-1:0] chk;
    send_byte(hdr_cfg);
    send_byte(tag);
    send_byte(len);
    for (int i = 0; i < len; i++) begin
      if (with_reads && $urandom_range(9) == 0) send_read(safe_read_index());
      send_byte(8'($urandom_range(255)));
    end
    chk = 8'($urandom_range(255));
    if (good) chk = chk_cfg;
    else if (chk == chk_cfg) chk = chk ^ 8'h01;
    send_byte(chk);
  endtask

  // Hold the input low until every predicted result has been taken
  task automatic drain();
    if (frame_reports.size() != 0) begin
      rx_if.valid <= 1'b0;
      while (frame_reports.size() != 0) @(posedge clk_i);
    end
  endtask

  task automatic set_config(logic [BYTE_W-1:0] hdr, logic [BYTE_W-1:0] chk);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= tlvfr_pkg::CFG_HEADER;
    cfg_wdata_i <= hdr;
    @(posedge clk_i);
    hdr_cfg      = hdr;
    cfg_idx_i   <= tlvfr_pkg::CFG_CHECK;
    cfg_wdata_i <= chk;
    @(posedge clk_i);
    chk_cfg   = chk;
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_directed();
    send_read(8'd0);
    send_read(8'd255);
    send_byte(8'h00);
    send_byte(8'hFF);
    // zero length goes straight to the check byte
    send_byte(hdr_cfg);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(chk_cfg);
    send_byte(hdr_cfg);
    send_byte(8'h00);
    send_byte(8'h02);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(chk_cfg ^ 8'hFF);
    send_read(8'd0);
    send_read(8'd1);
    send_read(8'd2);
    // read inside the new length before the payload arrives
    send_byte(hdr_cfg);
    send_byte(8'h5A);
    send_byte(8'h03);
    send_read(8'd1);
    send_byte(8'h11);
    send_byte(8'h22);
    send_byte(8'h33);
    send_byte(chk_cfg);
    send_read(8'd2);
  endtask

  task automatic test_config_extremes();
    drain();
    set_config(8'h00, 8'hFF);
    send_noise(3);
    send_frame(8'($urandom_range(255)), 8'd3, 1'b1, 1'b0);
    send_frame(8'($urandom_range(255)), 8'd0, 1'b0, 1'b0);
    drain();
    set_config(8'hFF, 8'h00);
    send_noise(3);
    send_frame(8'($urandom_range(255)), 8'd2, 1'b1, 1'b0);
    send_frame(8'($urandom_range(255)), 8'd1, 1'b0, 1'b1);
  endtask

  task automatic test_long_frame();
    send_frame(8'($urandom_range(255)), 8'd255, 1'b1, 1'b0);
    send_read(8'd0);
    send_read(8'd254);
    send_read(8'd255);
  endtask

  // Stall the output for a long stretch while input keeps coming, then pause until empty
  task automatic test_backpressure();
    drain();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = HOLD_CYCLES;
    send_frame(8'($urandom_range(255)), 8'd20, 1'b1, 1'b1);
    send_noise(5);
    drain();
  endtask

  task automatic run_random(int n);
    int target;
    int pick;
    logic [BYTE_W-1:0] len;
    target = items_sent + n;
    while (items_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 65) begin
        len = ($urandom_range(24) == 0) ? 8'($urandom_range(64)) : 8'($urandom_range(12));
        send_frame(8'($urandom_range(255)), len, $urandom_range(5) != 0, 1'b1);
      end else if (pick < 75) begin
        // cut-off frame: following bytes land in whatever phase it left
        send_byte(hdr_cfg);
        send_byte(8'($urandom_range(255)));
        if ($urandom_range(1) == 1) send_byte(8'($urandom_range(6)));
      end else if (pick < 88) begin
        repeat ($urandom_range(1, 4)) send_read(safe_read_index());
      end else if (pick < 98) begin
        send_noise($urandom_range(1, 4));
      end else begin
        drain();
      end
    end
  endtask

  task automatic test_random_phases();
    int send_pct [4] = '{0, 71, 0, 33};
    int recv_pct [4] = '{0, 0, 71, 33};
    for (int p = 0; p < 4; p++) begin
      drain();
      set_config(8'($urandom_range(255)), 8'($urandom_range(255)));
      send_idle_pct  = send_pct[p];
      recv_stall_pct = recv_pct[p];
      run_random(ITEMS_PER_PHASE);
    end
  endtask

  always @(posedge clk_i) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      tx_if.ready <= 1'b0;
    end else begin
      tx_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && tx_if.valid && tx_if.ready) begin
      if (frame_reports.size() == 0) begin
        error_count++;
        $display("%0t ns: unexpected result, expected none, actual ev %0h tag %0h len %0h pb %0h",
                 $time, tx_if.event_res, tx_if.frame_tag, tx_if.frame_length,
                 tx_if.payload_byte);
      end else begin
        head_report = frame_reports.pop_front();
        check_field("event_res", {6'd0, head_report.ev}, {6'd0, tx_if.event_res});
        check_field("frame_tag", head_report.tag, tx_if.frame_tag);
        check_field("frame_length", head_report.len, tx_if.frame_length);
        check_field("payload_byte", head_report.pbyte, tx_if.payload_byte);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (rx_if.valid && rx_if.ready) || (tx_if.valid && tx_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: watchdog expired with %0d results outstanding", $time,
               frame_reports.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = tlvfr_pkg::CFG_HEADER;
    cfg_wdata_i      = '0;
    rx_if.valid      = 1'b0;
    rx_if.mode       = tlvfr_pkg::MODE_RECV;
    rx_if.data_byte  = '0;
    rx_if.read_index = '0;
    tx_if.ready      = 1'b0;
    hdr_cfg          = tlvfr_pkg::HEADER_RST;
    chk_cfg          = tlvfr_pkg::CHECK_RST;
    rx_phase         = PH_HUNT;
    rx_pos           = '0;
    rx_tag           = '0;
    rx_len           = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_config_extremes();
    test_long_frame();
    test_backpressure();
    test_random_phases();

    drain();
    repeat (5) @(posedge clk_i);
    if (error_count == 0 && frame_reports.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/tlvfr_pkg.sv
rtl/tlvfr_in_if.sv
rtl/tlvfr_out_if.sv
rtl/tlvfr_payload_buf.sv
rtl/tlv_frame_receiver.sv
rtl/tlvfr_checker.sv
tb/tb_tlv_frame_receiver.sv
